// ===== rtl/core/dibrgba_pkg.sv =====
// Shared types and constants for the icon pixel to RGBA converter.
// Used by the palette, the conversion stage and the top level; depends on nothing.
package dibrgba_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_AW = $clog2(PALETTE_DEPTH);

   localparam logic [5:0] BPP_4 = 6'd4;
   localparam logic [5:0] BPP_8 = 6'd8;
   localparam logic [5:0] BPP_24 = 6'd24;
   localparam logic [5:0] BPP_32 = 6'd32;
   localparam logic [5:0] BPP_RESET = BPP_32;

   localparam logic ACTION_PALETTE = 1'b0;
   localparam logic ACTION_PIXEL = 1'b1;

   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [7:0] ALPHA_CLEAR = 8'd0;

   typedef logic [23:0] colour_type;

   typedef struct packed {
      logic we;
      logic [PAL_AW-1:0] waddr;
      colour_type wdata;
      logic re;
      logic [PAL_AW-1:0] raddr;
   } pal_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic unsupported;
   } pixel_type;

endpackage

// ===== rtl/core/dibrgba_palette.sv =====
// Palette memory with per-entry valid bits and a registered read port.
// Depends on dibrgba_pkg for the depth and the request structure.
module dibrgba_palette (
   input logic clock,
   input logic reset,
   input dibrgba_pkg::pal_req_type pal_req,
   output dibrgba_pkg::colour_type rd_colour
);

   dibrgba_pkg::colour_type palette_mem_ff [dibrgba_pkg::PALETTE_DEPTH];
   logic [dibrgba_pkg::PALETTE_DEPTH-1:0] valid_ff;
   dibrgba_pkg::colour_type rd_data_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (pal_req.we) begin
            valid_ff[pal_req.waddr] <= 1'b1;
         end
         if (pal_req.re) begin
            rd_valid_ff <= valid_ff[pal_req.raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pal_req.we) begin
         palette_mem_ff[pal_req.waddr] <= pal_req.wdata;
      end
      if (pal_req.re) begin
         rd_data_ff <= palette_mem_ff[pal_req.raddr];
      end
   end

   // An entry never written since reset reads as zero.
   assign rd_colour = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/core/dibrgba_convert.sv =====
// Depth-dependent conversion of one staged pixel into RGBA and the error flag.
// Depends on dibrgba_pkg for depth codes and the pixel structure.
module dibrgba_convert (
   input logic [5:0] bpp,
   input logic [31:0] raw_value,
   input logic mask_bit,
   input logic pal_hit,
   input dibrgba_pkg::colour_type pal_colour,
   output dibrgba_pkg::pixel_type pixel
);

   dibrgba_pkg::colour_type colour;
   logic [7:0] alpha;
   logic bad;

   always_comb begin
      colour = '0;
      alpha = dibrgba_pkg::ALPHA_OPAQUE;
      bad = 1'b0;
      unique case (bpp) inside
         dibrgba_pkg::BPP_32: begin
            colour = raw_value[23:0];
            alpha = raw_value[31:24];
         end
         dibrgba_pkg::BPP_24: begin
            colour = raw_value[23:0];
         end
         dibrgba_pkg::BPP_8, dibrgba_pkg::BPP_4: begin
            colour = pal_hit ? pal_colour : '0;
         end
         default: begin
            bad = 1'b1;
            alpha = dibrgba_pkg::ALPHA_CLEAR;
         end
      endcase
      if (mask_bit && (bpp != dibrgba_pkg::BPP_32)) begin
         alpha = dibrgba_pkg::ALPHA_CLEAR;
      end
      pixel.red = colour[23:16];
      pixel.green = colour[15:8];
      pixel.blue = colour[7:0];
      pixel.alpha = alpha;
      pixel.unsupported = bad;
   end

endmodule

// ===== rtl/core/dib_icon_pixel_to_rgba_unit.sv =====
// Top level of the icon pixel to RGBA converter: handshakes, pipeline and config register.
// Depends on dibrgba_pkg, dibrgba_palette and dibrgba_convert.
//
// The unit takes one beat per clock while the result side accepts, and returns one RGBA
// beat for every pixel beat, through the pixel stage and the result register. A palette
// beat writes its entry at the edge where it is accepted and returns nothing, so a
// pixel in the very next beat already sees the new entry. Each beat uses the palette
// once, either for the write or for the pixel lookup. Every palette entry reads as zero
// right after reset. Change the depth only while no pixel is in flight.
module dib_icon_pixel_to_rgba_unit (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic req_action,
   input logic [31:0] req_raw_value,
   input logic [7:0] req_palette_slot,
   input logic req_odd_column,
   input logic req_mask_bit,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic [7:0] rsp_alpha,
   output logic rsp_unsupported,
   input logic csr_valid,
   output logic csr_ready,
   input logic [5:0] csr_bits_per_pixel
);

   logic [5:0] bpp_ff;
   logic s1_valid_ff, s1_valid_in;
   logic [31:0] s1_raw_ff;
   logic s1_mask_ff;
   logic s1_hit_ff;
   logic rsp_valid_ff, rsp_valid_in;
   dibrgba_pkg::pixel_type rsp_pixel_ff;

   logic req_fire;
   logic s1_advance;
   logic [7:0] pix_idx;
   logic pix_hit;
   logic slot_ok;
   dibrgba_pkg::pal_req_type pal_req;
   dibrgba_pkg::colour_type pal_colour;
   dibrgba_pkg::pixel_type conv_pixel;

   assign csr_ready = 1'b1;
   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_advance;
   assign req_fire = req_valid && req_ready;

   always_comb begin
      if (bpp_ff == dibrgba_pkg::BPP_4) begin
         pix_idx = req_odd_column ? {4'd0, req_raw_value[3:0]} : {4'd0, req_raw_value[7:4]};
      end else begin
         pix_idx = req_raw_value[7:0];
      end
      pix_hit = {24'd0, pix_idx} < 32'(dibrgba_pkg::PALETTE_DEPTH);
      slot_ok = {24'd0, req_palette_slot} < 32'(dibrgba_pkg::PALETTE_DEPTH);
      pal_req.we = req_fire && (req_action == dibrgba_pkg::ACTION_PALETTE) && slot_ok;
      pal_req.waddr = req_palette_slot[dibrgba_pkg::PAL_AW-1:0];
      pal_req.wdata = req_raw_value[23:0];
      pal_req.re = req_fire && (req_action == dibrgba_pkg::ACTION_PIXEL) && pix_hit;
      pal_req.raddr = pix_idx[dibrgba_pkg::PAL_AW-1:0];
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = (req_action == dibrgba_pkg::ACTION_PIXEL);
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff <= dibrgba_pkg::BPP_RESET;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            bpp_ff <= csr_bits_per_pixel;
         end
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_action == dibrgba_pkg::ACTION_PIXEL)) begin
         s1_raw_ff <= req_raw_value;
         s1_mask_ff <= req_mask_bit;
         s1_hit_ff <= pix_hit;
      end
      if (s1_advance && s1_valid_ff) begin
         rsp_pixel_ff <= conv_pixel;
      end
   end

   dibrgba_palette u_palette (
      .clock(clock),
      .reset(reset),
      .pal_req(pal_req),
      .rd_colour(pal_colour)
   );

   dibrgba_convert u_convert (
      .bpp(bpp_ff),
      .raw_value(s1_raw_ff),
      .mask_bit(s1_mask_ff),
      .pal_hit(s1_hit_ff),
      .pal_colour(pal_colour),
      .pixel(conv_pixel)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red = rsp_pixel_ff.red;
   assign rsp_green = rsp_pixel_ff.green;
   assign rsp_blue = rsp_pixel_ff.blue;
   assign rsp_alpha = rsp_pixel_ff.alpha;
   assign rsp_unsupported = rsp_pixel_ff.unsupported;

`ifndef SYNTHESIS
   a_palette_beat_no_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_action == dibrgba_pkg::ACTION_PALETTE) |=> !s1_valid_ff)
      else $error("A palette beat entered the pixel stage.");

   a_pixel_beat_staged: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_action == dibrgba_pkg::ACTION_PIXEL) |=> s1_valid_ff)
      else $error("An accepted pixel beat was lost.");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_raw_ff))
      else $error("The pixel stage changed while stalled.");

   a_unsupported_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unsupported |-> (rsp_red == 8'd0) && (rsp_green == 8'd0)
         && (rsp_blue == 8'd0) && (rsp_alpha == 8'd0))
      else $error("An unsupported depth gave a nonzero pixel.");
`endif

endmodule

// ===== dv/dib_icon_pixel_to_rgba_unit_test.sv =====
// Self-checking testbench for the icon pixel to RGBA converter top level.
// Drives palette and pixel beats and depth writes, and predicts every RGBA beat.
// Depends on dibrgba_pkg and dib_icon_pixel_to_rgba_unit.
module dib_icon_pixel_to_rgba_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_COUNT = 12;
   localparam int BEATS_PER_PHASE = 120;
   localparam logic [5:0] DEPTH_ZERO = 6'd0;
   localparam logic [5:0] DEPTH_MAX = 6'd63;

   typedef struct {
      logic [5:0] bpp;
      logic action;
      logic [31:0] raw;
      logic [7:0] slot;
      logic odd;
      logic mask;
      bit typed;
      dibrgba_pkg::pixel_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_action;
   logic [31:0] req_raw_value;
   logic [7:0] req_palette_slot;
   logic req_odd_column;
   logic req_mask_bit;
   logic rsp_valid;
   logic rsp_ready;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic [7:0] rsp_alpha;
   logic rsp_unsupported;
   logic csr_valid;
   logic csr_ready;
   logic [5:0] csr_bits_per_pixel;

   dibrgba_pkg::colour_type colour_table [dibrgba_pkg::PALETTE_DEPTH];
   logic [5:0] depth_setting;
   dibrgba_pkg::pixel_type pixel_queue[$];
   stim_row_type directed_rows[$];
   int error_count = 0;
   int cycle_count = 0;
   bit steady = 1'b0;

   dib_icon_pixel_to_rgba_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_raw_value(req_raw_value),
      .req_palette_slot(req_palette_slot),
      .req_odd_column(req_odd_column),
      .req_mask_bit(req_mask_bit),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue),
      .rsp_alpha(rsp_alpha),
      .rsp_unsupported(rsp_unsupported),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_bits_per_pixel(csr_bits_per_pixel)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic dibrgba_pkg::pixel_type predict_pixel(logic [31:0] raw, logic odd,
                                                            logic mask);
      dibrgba_pkg::pixel_type px;
      dibrgba_pkg::colour_type colour;
      logic [3:0] nibble;
      colour = '0;
      px.alpha = dibrgba_pkg::ALPHA_OPAQUE;
      px.unsupported = 1'b0;
      case (depth_setting)
         dibrgba_pkg::BPP_32: begin
            colour = raw[23:0];
            px.alpha = raw[31:24];
         end
         dibrgba_pkg::BPP_24: begin
            colour = raw[23:0];
         end
         dibrgba_pkg::BPP_8: begin
            colour = colour_table[raw[7:0]];
         end
         dibrgba_pkg::BPP_4: begin
            nibble = odd ? raw[3:0] : raw[7:4];
            colour = colour_table[nibble];
         end
         default: begin
            px.unsupported = 1'b1;
            px.alpha = dibrgba_pkg::ALPHA_CLEAR;
         end
      endcase
      if (mask && depth_setting != dibrgba_pkg::BPP_32) begin
         px.alpha = dibrgba_pkg::ALPHA_CLEAR;
      end
      px.red = colour[23:16];
      px.green = colour[15:8];
      px.blue = colour[7:0];
      return px;
   endfunction

   task automatic add_row(stim_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic send_beat(logic action, logic [31:0] raw, logic [7:0] slot, logic odd,
                            logic mask, bit typed, dibrgba_pkg::pixel_type want);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_raw_value <= raw;
      req_palette_slot <= slot;
      req_odd_column <= odd;
      req_mask_bit <= mask;
      do @(posedge clock); while (!req_ready);
      if (action == dibrgba_pkg::ACTION_PALETTE) begin
         colour_table[slot] = raw[23:0];
      end else begin
         pixel_queue.insert(pixel_queue.size(), typed ? want : predict_pixel(raw, odd, mask));
      end
   endtask

   task automatic write_depth(logic [5:0] bpp);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_bits_per_pixel <= bpp;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      depth_setting = bpp;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      dibrgba_pkg::pixel_type want;
      int gap;
      rsp_ready = 1'b0;
      forever begin
         gap = steady ? 0 : $urandom_range(0, 8);
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pixel_queue.size() == 0) begin
            $error("RGBA beat arrived with no pixel outstanding");
            error_count++;
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_red !== want.red) begin
               $error("red: expected %0h, got %0h", want.red, rsp_red);
               error_count++;
            end
            if (rsp_green !== want.green) begin
               $error("green: expected %0h, got %0h", want.green, rsp_green);
               error_count++;
            end
            if (rsp_blue !== want.blue) begin
               $error("blue: expected %0h, got %0h", want.blue, rsp_blue);
               error_count++;
            end
            if (rsp_alpha !== want.alpha) begin
               $error("alpha: expected %0h, got %0h", want.alpha, rsp_alpha);
               error_count++;
            end
            if (rsp_unsupported !== want.unsupported) begin
               $error("unsupported: expected %0h, got %0h", want.unsupported,
                      rsp_unsupported);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [5:0] depth_plan [PHASE_COUNT];
      logic [5:0] supported [4];
      logic action;
      logic [7:0] slot;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = dibrgba_pkg::ACTION_PALETTE;
      req_raw_value = '0;
      req_palette_slot = '0;
      req_odd_column = 1'b0;
      req_mask_bit = 1'b0;
      csr_valid = 1'b0;
      csr_bits_per_pixel = '0;
      depth_setting = dibrgba_pkg::BPP_RESET;
      foreach (colour_table[i]) colour_table[i] = '0;

      add_row('{dibrgba_pkg::BPP_32, dibrgba_pkg::ACTION_PIXEL, 32'hAABBCCDD, 8'h00,
                1'b0, 1'b1, 1'b1, '{8'hBB, 8'hCC, 8'hDD, 8'hAA, 1'b0}});
      add_row('{dibrgba_pkg::BPP_32, dibrgba_pkg::ACTION_PIXEL, 32'hFFFFFFFF, 8'hFF,
                1'b1, 1'b0, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}});
      add_row('{dibrgba_pkg::BPP_32, dibrgba_pkg::ACTION_PIXEL, 32'h00000000, 8'h00,
                1'b0, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}});
      add_row('{dibrgba_pkg::BPP_32, dibrgba_pkg::ACTION_PIXEL, 32'h00FF00FF, 8'h00,
                1'b0, 1'b1, 1'b1, '{8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0}});
      add_row('{dibrgba_pkg::BPP_8, dibrgba_pkg::ACTION_PIXEL, 32'h000000FF, 8'h00,
                1'b0, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b0}});
      add_row('{dibrgba_pkg::BPP_8, dibrgba_pkg::ACTION_PALETTE, 32'hFF123456, 8'h00,
                1'b1, 1'b1, 1'b0, '0});
      add_row('{dibrgba_pkg::BPP_8, dibrgba_pkg::ACTION_PALETTE, 32'h00FFFFFF, 8'hFF,
                1'b0, 1'b0, 1'b0, '0});
      add_row('{dibrgba_pkg::BPP_8, dibrgba_pkg::ACTION_PALETTE, 32'h00ABCDEF, 8'h0F,
                1'b0, 1'b0, 1'b0, '0});
      add_row('{dibrgba_pkg::BPP_8, dibrgba_pkg::ACTION_PALETTE, 32'h00010203, 8'h01,
                1'b0, 1'b0, 1'b0, '0});
      add_row('{dibrgba_pkg::BPP_8, dibrgba_pkg::ACTION_PIXEL, 32'hFFFFFF00, 8'hFF,
                1'b1, 1'b1, 1'b0, '0});
      add_row('{dibrgba_pkg::BPP_8, dibrgba_pkg::ACTION_PIXEL, 32'h000000FF, 8'h00,
                1'b0, 1'b0, 1'b0, '0});
      add_row('{dibrgba_pkg::BPP_8, dibrgba_pkg::ACTION_PIXEL, 32'h000000FF, 8'h00,
                1'b0, 1'b1, 1'b0, '0});
      add_row('{dibrgba_pkg::BPP_4, dibrgba_pkg::ACTION_PIXEL, 32'h0000000F, 8'h00,
                1'b1, 1'b0, 1'b0, '0});
      add_row('{dibrgba_pkg::BPP_4, dibrgba_pkg::ACTION_PIXEL, 32'h0000000F, 8'h00,
                1'b0, 1'b0, 1'b0, '0});
      add_row('{dibrgba_pkg::BPP_4, dibrgba_pkg::ACTION_PIXEL, 32'hFFFFFFF1, 8'h00,
                1'b0, 1'b1, 1'b0, '0});
      add_row('{dibrgba_pkg::BPP_4, dibrgba_pkg::ACTION_PIXEL, 32'h000000F1, 8'h00,
                1'b1, 1'b0, 1'b0, '0});
      add_row('{dibrgba_pkg::BPP_24, dibrgba_pkg::ACTION_PIXEL, 32'h12345678, 8'h00,
                1'b0, 1'b0, 1'b1, '{8'h34, 8'h56, 8'h78, 8'hFF, 1'b0}});
      add_row('{dibrgba_pkg::BPP_24, dibrgba_pkg::ACTION_PIXEL, 32'hFFFFFFFF, 8'hFF,
                1'b1, 1'b1, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0}});
      add_row('{DEPTH_ZERO, dibrgba_pkg::ACTION_PIXEL, 32'hFFFFFFFF, 8'h00,
                1'b0, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}});
      add_row('{DEPTH_MAX, dibrgba_pkg::ACTION_PIXEL, 32'h12345678, 8'h00,
                1'b1, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}});
      add_row('{DEPTH_MAX, dibrgba_pkg::ACTION_PALETTE, 32'h000A0B0C, 8'h02,
                1'b0, 1'b0, 1'b0, '0});
      add_row('{dibrgba_pkg::BPP_8, dibrgba_pkg::ACTION_PIXEL, 32'h00000002, 8'h00,
                1'b0, 1'b0, 1'b0, '0});

      supported[0] = dibrgba_pkg::BPP_4;
      supported[1] = dibrgba_pkg::BPP_8;
      supported[2] = dibrgba_pkg::BPP_24;
      supported[3] = dibrgba_pkg::BPP_32;
      depth_plan[0] = dibrgba_pkg::BPP_4;
      depth_plan[1] = dibrgba_pkg::BPP_8;
      depth_plan[2] = dibrgba_pkg::BPP_24;
      depth_plan[3] = dibrgba_pkg::BPP_32;
      depth_plan[4] = DEPTH_ZERO;
      depth_plan[5] = DEPTH_MAX;
      for (int p = 6; p < PHASE_COUNT; p++) begin
         if ($urandom_range(0, 3) == 0) begin
            depth_plan[p] = 6'($urandom_range(0, 63));
         end else begin
            depth_plan[p] = supported[$urandom_range(0, 3)];
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].bpp != depth_setting) begin
            write_depth(directed_rows[i].bpp);
         end
         send_beat(directed_rows[i].action, directed_rows[i].raw, directed_rows[i].slot,
                   directed_rows[i].odd, directed_rows[i].mask, directed_rows[i].typed,
                   directed_rows[i].want);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_depth(depth_plan[p]);
         steady = (p % 4 == 1);
         repeat (BEATS_PER_PHASE) begin
            action = ($urandom_range(0, 9) < 3) ? dibrgba_pkg::ACTION_PALETTE
                                                : dibrgba_pkg::ACTION_PIXEL;
            slot = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
            send_beat(action, $urandom(), slot, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, '0);
         end
      end
      steady = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
